### hdl/dltq_pkg.sv
`timescale 1ns / 1ps
package dltq_pkg;

  // Operation codes on the command port
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_ADDED     = 2'd0,
    KIND_CANCELLED = 2'd1,
    KIND_EXPIRED   = 2'd2,
    KIND_DONE      = 2'd3
  } kind_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_e;

  // Datapath actions issued by the controller
  typedef enum logic [4:0] {
    ACT_NONE,
    ACT_LOAD_ACC,
    ACT_LOAD_SUM,
    ACT_FULL,
    ACT_RD_IDX,
    ACT_ADD_EV,
    ACT_ADD_RDJ,
    ACT_ADD_WRJ,
    ACT_ADD_INS,
    ACT_CAN_EV,
    ACT_CAN_RDJ,
    ACT_CAN_WRJ,
    ACT_CAN_NF,
    ACT_CAN_OK,
    ACT_TCK_EV,
    ACT_TCK_RDE,
    ACT_TCK_EMIT,
    ACT_TCK_SET,
    ACT_TCK_RDJ,
    ACT_TCK_WRJ,
    ACT_TCK_FIN
  } dp_act_e;

  typedef struct packed {
    dp_act_e act;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic idx_end;
    logic jdx_pos;
    logic jdx_zero;
    logic jdx_end;
    logic ge;
    logic match;
  } dp_stat_t;

endpackage

### hdl/dltq_ram.sv
`timescale 1ns / 1ps
module dltq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/dltq_ctrl.sv
`timescale 1ns / 1ps
module dltq_ctrl
  import dltq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] operation_i,
  input  dp_stat_t   stat_i,
  output dp_cmd_t    cmd_o,
  output logic       busy
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_RD, S_A_EV, S_A_SHR, S_A_SHW,
    S_C_RD, S_C_EV, S_C_SHR, S_C_SHW,
    S_T_RD, S_T_EV, S_T_EM, S_T_EO, S_T_SHR, S_T_SHW
  } state_e;

  state_e state_q, state_d;
  dp_act_e act;

  // next state and datapath action
  always_comb begin
    state_d = state_q;
    act     = ACT_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (operation_i == OP_ADD) begin
            if (stat_i.full) begin
              act = ACT_FULL;
            end else begin
              act     = ACT_LOAD_ACC;
              state_d = S_A_RD;
            end
          end else if (operation_i == OP_CANCEL) begin
            act     = ACT_LOAD_SUM;
            state_d = S_C_RD;
          end else if (operation_i == OP_TICK) begin
            act     = ACT_LOAD_ACC;
            state_d = S_T_RD;
          end
        end
      end
      // add: walk to the insertion point, open a gap, write
      S_A_RD: begin
        if (stat_i.idx_end) begin
          state_d = S_A_SHR;
        end else begin
          act     = ACT_RD_IDX;
          state_d = S_A_EV;
        end
      end
      S_A_EV: begin
        act     = ACT_ADD_EV;
        state_d = stat_i.ge ? S_A_RD : S_A_SHR;
      end
      S_A_SHR: begin
        if (stat_i.jdx_pos) begin
          act     = ACT_ADD_INS;
          state_d = S_IDLE;
        end else begin
          act     = ACT_ADD_RDJ;
          state_d = S_A_SHW;
        end
      end
      S_A_SHW: begin
        act     = ACT_ADD_WRJ;
        state_d = S_A_SHR;
      end
      // cancel: walk summing delays, then close the gap
      S_C_RD: begin
        if (stat_i.idx_end) begin
          act     = ACT_CAN_NF;
          state_d = S_IDLE;
        end else begin
          act     = ACT_RD_IDX;
          state_d = S_C_EV;
        end
      end
      S_C_EV: begin
        act     = ACT_CAN_EV;
        state_d = stat_i.match ? S_C_SHR : S_C_RD;
      end
      S_C_SHR: begin
        if (stat_i.jdx_end) begin
          act     = ACT_CAN_OK;
          state_d = S_IDLE;
        end else begin
          act     = ACT_CAN_RDJ;
          state_d = S_C_SHW;
        end
      end
      S_C_SHW: begin
        act     = ACT_CAN_WRJ;
        state_d = S_C_SHR;
      end
      // tick: count due entries, emit them backwards, compact
      S_T_RD: begin
        if (stat_i.idx_end) begin
          state_d = S_T_EM;
        end else begin
          act     = ACT_RD_IDX;
          state_d = S_T_EV;
        end
      end
      S_T_EV: begin
        act     = ACT_TCK_EV;
        state_d = stat_i.ge ? S_T_RD : S_T_EM;
      end
      S_T_EM: begin
        if (stat_i.jdx_zero) begin
          act     = ACT_TCK_SET;
          state_d = S_T_SHR;
        end else begin
          act     = ACT_TCK_RDE;
          state_d = S_T_EO;
        end
      end
      S_T_EO: begin
        act     = ACT_TCK_EMIT;
        state_d = S_T_EM;
      end
      S_T_SHR: begin
        if (stat_i.jdx_end) begin
          act     = ACT_TCK_FIN;
          state_d = S_IDLE;
        end else begin
          act     = ACT_TCK_RDJ;
          state_d = S_T_SHW;
        end
      end
      S_T_SHW: begin
        act     = ACT_TCK_WRJ;
        state_d = S_T_SHR;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.act = act;
  assign busy      = (state_q != S_IDLE);

endmodule

### hdl/dltq_dp.sv
`timescale 1ns / 1ps
module dltq_dp
  import dltq_pkg::*;
#(
  parameter int ENTRIES = 16,
  parameter int ID_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  input  logic [31:0] amount_i,
  input  logic [15:0] target_id_i,
  input  logic [15:0] user_tag_i,
  output dp_stat_t    stat_o,
  output logic        strobe_o,
  output logic [1:0]  kind_o,
  output logic [1:0]  status_o,
  output logic [15:0] result_id_o,
  output logic [15:0] result_tag_o,
  output logic [31:0] remaining_o,
  output logic        last_o
);

  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int ADDR_W = $clog2(ENTRIES);
  localparam int E_W    = 32 + ID_BITS + 16;

  // list state
  logic [CNT_W-1:0]   count_q, count_d;
  logic [ID_BITS-1:0] nid_q, nid_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]   jdx_q, jdx_d;
  logic [31:0]        acc_q, acc_d;
  logic [31:0]        dly_q, dly_d;
  logic [15:0]        tgt_q, tgt_d;
  logic [15:0]        tag_q, tag_d;
  logic [ID_BITS-1:0] hid_q, hid_d;
  logic [15:0]        htag_q, htag_d;

  // result register
  logic        strobe_q, strobe_d;
  logic [1:0]  kind_q, kind_d;
  logic [1:0]  status_q, status_d;
  logic [15:0] rid_q, rid_d;
  logic [15:0] rtag_q, rtag_d;
  logic [31:0] rem_q, rem_d;
  logic        last_q, last_d;

  // RAM port
  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [E_W-1:0]    wdata, rdata;

  logic [31:0]        rd_delay;
  logic [ID_BITS-1:0] rd_id;
  logic [15:0]        rd_tag;
  logic [ID_BITS+15:0] id_ext, tgt_ext, hid_ext, nid_ext;
  logic [32:0]        sum;
  logic [CNT_W-1:0]   idx_p1, jdx_m1, jdx_off;

  dltq_ram #(
    .WIDTH(E_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rd_delay = rdata[E_W-1 -: 32];
  assign rd_id    = rdata[16 +: ID_BITS];
  assign rd_tag   = rdata[15:0];
  assign id_ext   = {16'b0, rd_id};
  assign tgt_ext  = {{ID_BITS{1'b0}}, tgt_q};
  assign hid_ext  = {16'b0, hid_q};
  assign nid_ext  = {16'b0, nid_q};
  assign sum      = {1'b0, acc_q} + {1'b0, rd_delay};
  assign idx_p1   = idx_q + CNT_W'(1);
  assign jdx_m1   = jdx_q - CNT_W'(1);
  assign jdx_off  = jdx_q - idx_q;

  // status to the controller
  assign stat_o.full     = (count_q == CNT_W'(ENTRIES));
  assign stat_o.idx_end  = (idx_q == count_q);
  assign stat_o.jdx_pos  = (jdx_q == idx_q);
  assign stat_o.jdx_zero = (jdx_q == '0);
  assign stat_o.jdx_end  = (jdx_q == count_q);
  assign stat_o.ge       = (acc_q >= rd_delay);
  assign stat_o.match    = (id_ext == tgt_ext);

  // datapath actions
  always_comb begin
    count_d  = count_q;
    nid_d    = nid_q;
    idx_d    = idx_q;
    jdx_d    = jdx_q;
    acc_d    = acc_q;
    dly_d    = dly_q;
    tgt_d    = tgt_q;
    tag_d    = tag_q;
    hid_d    = hid_q;
    htag_d   = htag_q;
    strobe_d = 1'b0;
    kind_d   = kind_q;
    status_d = status_q;
    rid_d    = rid_q;
    rtag_d   = rtag_q;
    rem_d    = rem_q;
    last_d   = last_q;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = idx_q[ADDR_W-1:0];
    raddr    = idx_q[ADDR_W-1:0];
    wdata    = rdata;
    unique case (cmd_i.act) inside
      ACT_NONE: begin
      end
      ACT_LOAD_ACC, ACT_LOAD_SUM: begin
        acc_d = (cmd_i.act == ACT_LOAD_SUM) ? 32'd0 : amount_i;
        tgt_d = target_id_i;
        tag_d = user_tag_i;
        idx_d = '0;
        jdx_d = count_q;
      end
      ACT_FULL: begin
        strobe_d = 1'b1;
        kind_d   = KIND_ADDED;
        status_d = STAT_FULL;
        rid_d    = '0;
        rtag_d   = '0;
        rem_d    = '0;
        last_d   = 1'b1;
      end
      ACT_RD_IDX: begin
        re = 1'b1;
      end
      ACT_ADD_EV: begin
        jdx_d = count_q;
        if (acc_q >= rd_delay) begin
          acc_d = acc_q - rd_delay;
          idx_d = idx_p1;
        end
      end
      ACT_ADD_RDJ, ACT_TCK_RDE: begin
        re    = 1'b1;
        raddr = jdx_m1[ADDR_W-1:0];
      end
      ACT_ADD_WRJ: begin
        // entry moves up one; the old entry at the insertion point loses rem
        we    = 1'b1;
        waddr = jdx_q[ADDR_W-1:0];
        wdata = {(jdx_q == idx_p1) ? rd_delay - acc_q : rd_delay, rd_id, rd_tag};
        jdx_d = jdx_m1;
      end
      ACT_ADD_INS: begin
        we       = 1'b1;
        wdata    = {acc_q, nid_q, tag_q};
        count_d  = count_q + CNT_W'(1);
        nid_d    = nid_q + ID_BITS'(1);
        strobe_d = 1'b1;
        kind_d   = KIND_ADDED;
        status_d = STAT_OK;
        rid_d    = nid_ext[15:0];
        rtag_d   = '0;
        rem_d    = '0;
        last_d   = 1'b1;
      end
      ACT_CAN_EV: begin
        // saturating running sum of delays
        acc_d = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        if (id_ext == tgt_ext) begin
          hid_d  = rd_id;
          htag_d = rd_tag;
          dly_d  = rd_delay;
          jdx_d  = idx_p1;
        end else begin
          idx_d = idx_p1;
        end
      end
      ACT_CAN_RDJ, ACT_TCK_RDJ: begin
        re    = 1'b1;
        raddr = jdx_q[ADDR_W-1:0];
      end
      ACT_CAN_WRJ: begin
        // follower of the removed entry absorbs its delay
        we    = 1'b1;
        waddr = jdx_m1[ADDR_W-1:0];
        wdata = {(jdx_q == idx_p1) ? rd_delay + dly_q : rd_delay, rd_id, rd_tag};
        jdx_d = jdx_q + CNT_W'(1);
      end
      ACT_CAN_NF: begin
        strobe_d = 1'b1;
        kind_d   = KIND_CANCELLED;
        status_d = STAT_NOT_FOUND;
        rid_d    = tgt_q;
        rtag_d   = '0;
        rem_d    = '0;
        last_d   = 1'b1;
      end
      ACT_CAN_OK: begin
        count_d  = count_q - CNT_W'(1);
        strobe_d = 1'b1;
        kind_d   = KIND_CANCELLED;
        status_d = STAT_OK;
        rid_d    = hid_ext[15:0];
        rtag_d   = htag_q;
        rem_d    = acc_q;
        last_d   = 1'b1;
      end
      ACT_TCK_EV: begin
        if (acc_q >= rd_delay) begin
          acc_d = acc_q - rd_delay;
          idx_d = idx_p1;
          jdx_d = idx_p1;
        end else begin
          jdx_d = idx_q;
        end
      end
      ACT_TCK_EMIT: begin
        strobe_d = 1'b1;
        kind_d   = KIND_EXPIRED;
        status_d = STAT_OK;
        rid_d    = id_ext[15:0];
        rtag_d   = rd_tag;
        rem_d    = '0;
        last_d   = 1'b0;
        jdx_d    = jdx_m1;
      end
      ACT_TCK_SET: begin
        jdx_d = idx_q;
      end
      ACT_TCK_WRJ: begin
        // compact down by the expired count; new head loses the leftover
        we    = 1'b1;
        waddr = jdx_off[ADDR_W-1:0];
        wdata = {(jdx_q == idx_q) ? rd_delay - acc_q : rd_delay, rd_id, rd_tag};
        jdx_d = jdx_q + CNT_W'(1);
      end
      ACT_TCK_FIN: begin
        count_d  = count_q - idx_q;
        strobe_d = 1'b1;
        kind_d   = KIND_DONE;
        status_d = STAT_OK;
        rid_d    = '0;
        rtag_d   = '0;
        rem_d    = '0;
        last_d   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      nid_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      nid_q    <= nid_d;
      strobe_q <= strobe_d;
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    jdx_q    <= jdx_d;
    acc_q    <= acc_d;
    dly_q    <= dly_d;
    tgt_q    <= tgt_d;
    tag_q    <= tag_d;
    hid_q    <= hid_d;
    htag_q   <= htag_d;
    kind_q   <= kind_d;
    status_q <= status_d;
    rid_q    <= rid_d;
    rtag_q   <= rtag_d;
    rem_q    <= rem_d;
    last_q   <= last_d;
  end

  assign strobe_o     = strobe_q;
  assign kind_o       = kind_q;
  assign status_o     = status_q;
  assign result_id_o  = rid_q;
  assign result_tag_o = rtag_q;
  assign remaining_o  = rem_q;
  assign last_o       = last_q;

endmodule

### hdl/delta_list_timer_queue_top.sv
// A full add is answered straight from idle without walking the list; an unknown operation
// gives no result. One transaction at a time: busy falls as the last result strobes. Each
// entry visit is split over a state that issues the registered RAM read and a state that
// uses the data; the receiver cannot stall results.
// Reset clears the alarm count and the identifier counter; the list RAM is not cleared.
`timescale 1ns / 1ps
module delta_list_timer_queue_top
  import dltq_pkg::*;
#(
  parameter int ENTRIES = 16,
  parameter int ID_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [31:0] amount_i,
  input  logic [15:0] target_id_i,
  input  logic [15:0] user_tag_i,
  output logic        strobe_o,
  output logic [1:0]  kind_o,
  output logic [1:0]  status_o,
  output logic [15:0] result_id_o,
  output logic [15:0] result_tag_o,
  output logic [31:0] remaining_o,
  output logic        last_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  dltq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .operation_i(operation_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy       (busy)
  );

  dltq_dp #(
    .ENTRIES(ENTRIES),
    .ID_BITS(ID_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .amount_i    (amount_i),
    .target_id_i (target_id_i),
    .user_tag_i  (user_tag_i),
    .stat_o      (stat),
    .strobe_o    (strobe_o),
    .kind_o      (kind_o),
    .status_o    (status_o),
    .result_id_o (result_id_o),
    .result_tag_o(result_tag_o),
    .remaining_o (remaining_o),
    .last_o      (last_o)
  );

endmodule
